// ----- hw/rtl/imm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

	// Configuration port.
	localparam int CFG_W        = 4;
	localparam int CFG_ADDR_W   = 4;
	localparam int CFG_DATA_W   = 32;
	localparam int REG_IDX_W    = 2;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

	// Result fields.
	localparam int PROD_W = 35;
	localparam int POS_W  = 3;

	// Matrix sizes after clamping to the range 1 .. MAX_DIM.
	typedef struct packed {
		logic [CFG_W-1:0] rows_a;
		logic [CFG_W-1:0] cols_a;
		logic [CFG_W-1:0] rows_b;
		logic [CFG_W-1:0] cols_b;
	} dims_t;

	// Controller to datapath.
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_en;
		logic             first;
		logic             load_result;
		logic             load_error;
		logic             res_last;
		logic [POS_W-1:0] res_row;
		logic [POS_W-1:0] res_col;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/imm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/imm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_cfg
// Size registers behind the APB port, with clamped sizes for the core.
// ----------------------------------------------------------------------------
module imm_cfg
	import imm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output dims_t                 dims,
	output logic                  restart
);

	logic [CFG_W-1:0]     rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [CFG_W-1:0]     rd_val;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = CFG_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign restart = wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CFG_RESET;
			cols_a_q <= CFG_RESET;
			rows_b_q <= CFG_RESET;
			cols_b_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ROWS_A: rows_a_q <= pwdata[CFG_W-1:0];
				REG_COLS_A: cols_a_q <= pwdata[CFG_W-1:0];
				REG_ROWS_B: rows_b_q <= pwdata[CFG_W-1:0];
				REG_COLS_B: cols_b_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROWS_A: rd_val = rows_a_q;
			REG_COLS_A: rd_val = cols_a_q;
			REG_ROWS_B: rd_val = rows_b_q;
			REG_COLS_B: rd_val = cols_b_q;
			default:    rd_val = '0;
		endcase
	end

	assign prdata = CFG_DATA_W'(rd_val);

	assign dims.rows_a = clamp_dim(rows_a_q);
	assign dims.cols_a = clamp_dim(cols_a_q);
	assign dims.rows_b = clamp_dim(rows_b_q);
	assign dims.cols_b = clamp_dim(cols_b_q);

endmodule

// ----- hw/rtl/imm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer: load counters for A and B, then the row, column and dot
// product counters that drive the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module imm_ctrl
	import imm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  dims_t   dims,
	input  logic    restart,
	input  logic    elem_valid,
	output logic    elem_stall,
	input  status_t status,
	output cmd_t    cmd,
	output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_a,
	output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_b
);

	localparam int IDX_W  = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1;

	typedef enum logic [2:0] {
		S_LOAD  = 3'b001,
		S_MAC   = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] ld_row_q, ld_col_q;
	logic             loading_b_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;

	logic [IDX_W-1:0] ra_m1, ca_m1, rb_m1, cb_m1;
	logic [IDX_W-1:0] cur_rows_m1, cur_cols_m1;
	logic             mismatch, accept;
	logic             ld_last_col, ld_last;
	logic             r_last, c_last, k_last, emit;

	assign ra_m1 = IDX_W'(dims.rows_a - CFG_W'(1));
	assign ca_m1 = IDX_W'(dims.cols_a - CFG_W'(1));
	assign rb_m1 = IDX_W'(dims.rows_b - CFG_W'(1));
	assign cb_m1 = IDX_W'(dims.cols_b - CFG_W'(1));

	assign mismatch    = dims.cols_a != dims.rows_b;
	assign cur_rows_m1 = loading_b_q ? rb_m1 : ra_m1;
	assign cur_cols_m1 = loading_b_q ? cb_m1 : ca_m1;
	assign ld_last_col = ld_col_q == cur_cols_m1;
	assign ld_last     = ld_last_col && (ld_row_q == cur_rows_m1);

	assign r_last = r_q == ra_m1;
	assign c_last = c_q == cb_m1;
	assign k_last = k_q == ca_m1;

	// An error result needs the output register; plain loads do not.
	assign elem_stall = (state_q != S_LOAD) || (mismatch && !status.out_free);
	assign accept     = elem_valid && !elem_stall;
	assign emit       = (state_q == S_FLUSH) && !status.busy && status.out_free;

	assign wr_addr   = ADDR_W'(ld_row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col_q);
	assign rd_addr_a = ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign rd_addr_b = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q);

	always_comb begin
		cmd             = '0;
		cmd.res_row     = POS_W'(r_q);
		cmd.res_col     = POS_W'(c_q);
		cmd.res_last    = r_last && c_last;
		case (state_q)
			S_LOAD: begin
				cmd.load_error = accept && mismatch;
				cmd.wr_a       = accept && !mismatch && !loading_b_q;
				cmd.wr_b       = accept && !mismatch && loading_b_q;
			end
			S_MAC: begin
				cmd.rd_en = 1'b1;
				cmd.first = k_q == '0;
			end
			S_FLUSH: begin
				cmd.load_result = emit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ld_row_q    <= '0;
			ld_col_q    <= '0;
			loading_b_q <= 1'b0;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
		end else if (restart) begin
			ld_row_q    <= '0;
			ld_col_q    <= '0;
			loading_b_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept && !mismatch) begin
						if (ld_last) begin
							ld_row_q    <= '0;
							ld_col_q    <= '0;
							loading_b_q <= !loading_b_q;
							if (loading_b_q) begin
								state_q <= S_MAC;
								r_q     <= '0;
								c_q     <= '0;
								k_q     <= '0;
							end
						end else if (ld_last_col) begin
							ld_col_q <= '0;
							ld_row_q <= ld_row_q + IDX_W'(1);
						end else begin
							ld_col_q <= ld_col_q + IDX_W'(1);
						end
					end
				end
				S_MAC: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= S_FLUSH;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_FLUSH: begin
					if (emit) begin
						if (c_last) begin
							c_q <= '0;
							if (r_last) begin
								r_q     <= '0;
								state_q <= S_LOAD;
							end else begin
								r_q     <= r_q + IDX_W'(1);
								state_q <= S_MAC;
							end
						end else begin
							c_q     <= c_q + IDX_W'(1);
							state_q <= S_MAC;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ----- hw/rtl/imm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_dp
// Element stores, pipelined multiply-accumulate and the result register.
// ----------------------------------------------------------------------------
module imm_dp
	import imm_pkg::*;
#(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_a,
	input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_b,
	input  logic [ELEMENT_WIDTH-1:0] element_value,
	output status_t                  status,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [PROD_W-1:0]        product_value,
	output logic [POS_W-1:0]         row_index,
	output logic [POS_W-1:0]         col_index,
	output logic                     last_of_run,
	output logic                     dim_error
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [ELEMENT_WIDTH-1:0]       a_rd, b_rd;
	logic                           issue_s1, first_s1;
	logic                           valid_s2, first_s2;
	logic signed [2*ELEMENT_WIDTH-1:0] mult;
	logic signed [PROD_W-1:0]       prod_s2;
	logic [PROD_W-1:0]              acc_q;
	logic                           res_valid_q;

	imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (wr_addr),
		.wdata (element_value),
		.re    (cmd.rd_en),
		.raddr (rd_addr_a),
		.rdata (a_rd)
	);

	imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (wr_addr),
		.wdata (element_value),
		.re    (cmd.rd_en),
		.raddr (rd_addr_b),
		.rdata (b_rd)
	);

	assign mult = $signed(a_rd) * $signed(b_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			issue_s1 <= cmd.rd_en;
			valid_s2 <= issue_s1;
		end
	end

	// Sums wrap at the result width; the signed cast sign-extends narrow products.
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		first_s2 <= first_s1;
		prod_s2  <= PROD_W'(mult);
		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + prod_s2;
		end
	end

	assign status.busy     = issue_s1 || valid_s2;
	assign status.out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_error) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			product_value <= acc_q;
			row_index     <= cmd.res_row;
			col_index     <= cmd.res_col;
			last_of_run   <= cmd.res_last;
			dim_error     <= 1'b0;
		end else if (cmd.load_error) begin
			product_value <= '0;
			row_index     <= '0;
			col_index     <= '0;
			last_of_run   <= 1'b1;
			dim_error     <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ----- hw/rtl/integer_matrix_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Loads A then B row-major, then streams out C = A * B row-major.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  elem     | in        | elem_valid/elem_stall | element_value
//  res      | out       | res_valid/res_stall   | product_value, row_index,
//           |           |                       | col_index, last_of_run, dim_error
//  apb      | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// Elements are taken one per cycle while loading; an error beat waits only for
// a free result register. After the last element of B the elements of C are
// formed at one product per cycle on the single multiply-accumulate unit fed
// by the two store read ports, then pass two pipeline stages and the write of
// the result register. No new element is taken until C has been written.
// A result stalled on res_stall holds the unit. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
	import imm_pkg::*;
#(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0]    pwdata,
	output logic [CFG_DATA_W-1:0]    prdata,
	output logic                     pready,
	input  logic                     elem_valid,
	output logic                     elem_stall,
	input  logic [ELEMENT_WIDTH-1:0] element_value,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [PROD_W-1:0]        product_value,
	output logic [POS_W-1:0]         row_index,
	output logic [POS_W-1:0]         col_index,
	output logic                     last_of_run,
	output logic                     dim_error
);

	localparam int ADDR_W = MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1;

	dims_t             dims;
	logic              restart;
	cmd_t              cmd;
	status_t           status;
	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

	imm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims),
		.restart (restart)
	);

	imm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.restart    (restart),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.status     (status),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b)
	);

	imm_dp #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.element_value (element_value),
		.status        (status),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.product_value (product_value),
		.row_index     (row_index),
		.col_index     (col_index),
		.last_of_run   (last_of_run),
		.dim_error     (dim_error)
	);

endmodule

// ----- hw/rtl/imm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks on the result channel of the matrix multiplier.
// ----------------------------------------------------------------------------
module imm_checker
	import imm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_stall,
	input logic [PROD_W-1:0] product_value,
	input logic [POS_W-1:0]  row_index,
	input logic [POS_W-1:0]  col_index,
	input logic              last_of_run,
	input logic              dim_error
);

	// A stalled beat stays and keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(product_value) &&
			$stable(row_index) && $stable(col_index) &&
			$stable(last_of_run) && $stable(dim_error))
		else $error("stalled result beat changed");

	// An error beat always closes a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dim_error |-> last_of_run)
		else $error("error beat without last_of_run");

	// An error beat carries no product and no position.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dim_error |-> product_value == '0 && row_index == '0 &&
			col_index == '0)
		else $error("error beat carries data");

	// The result register is empty while reset is held.
	assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.product_value (product_value),
	.row_index     (row_index),
	.col_index     (col_index),
	.last_of_run   (last_of_run),
	.dim_error     (dim_error)
);
